@@ rtl/windows_path_name_checker_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the path name checker
// Shared wrappers that keep the checker's concurrent assertions uniform.
// ----------------------------------------------------------------------------
`ifndef WINDOWS_PATH_NAME_CHECKER_UNIT_ASSERT_SVH
`define WINDOWS_PATH_NAME_CHECKER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPNC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WPNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after reset is applied.
`define WPNC_ASSERT_AFTER_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/wpnc_pkg.sv @@
// ----------------------------------------------------------------------------
// wpnc_pkg
// Types, byte codes and character classes shared by the path name checker.
// ----------------------------------------------------------------------------
package wpnc_pkg;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    localparam int NAME_COUNT = 6;
    localparam logic [23:0] DEVICE_NAMES [NAME_COUNT] =
        '{"CON", "NUL", "AUX", "PRN", "COM", "LPT"};
    localparam logic [NAME_COUNT-1:0] NEEDS_DIGIT = 6'b110000;

    localparam logic [1:0] PH_NONE  = 2'd0;
    localparam logic [1:0] PH_NAMED = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    localparam logic [2:0] LEN_MAX   = 3'd5;
    localparam logic [2:0] HEAD_LEN  = 3'd3;
    localparam logic [2:0] LEAD_LEN  = 3'd4;
    localparam logic [1:0] NPOS_MAX  = 2'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] pbyte;
    } t_item;

    typedef struct packed {
        logic load;
        logic illegal;
    } t_result;

    typedef struct packed {
        logic [2:0] elen;
        logic [1:0] phase;
        logic [7:0] prev;
        logic       illegal;
        logic [1:0] npos;
    } t_walk;

    localparam t_walk WALK_RESET = '{elen: 3'd0, phase: PH_NONE, prev: 8'd0,
                                     illegal: 1'b0, npos: 2'd0};

    function automatic logic is_delim(input logic [7:0] c);
        return (c == CH_SLASH) || (c == CH_BSLASH);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
    endfunction

    function automatic logic is_digit19(input logic [7:0] c);
        return (c >= CH_ONE) && (c <= CH_NINE);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= CH_LO_A) && (c <= CH_LO_Z)) ? (c - CASE_GAP) : c;
    endfunction

    function automatic logic byte_allowed(input logic [7:0] c);
        return !((c < CH_SPACE) || (c == CH_DEL) || (c == CH_QUOTE) || (c == CH_STAR) ||
                 (c == CH_SLASH) || (c == CH_COLON) || (c == CH_LT) || (c == CH_GT) ||
                 (c == CH_QUEST) || (c == CH_BSLASH) || (c == CH_BAR));
    endfunction

    function automatic logic [1:0] device_phase_of(input logic [7:0] a,
                                                   input logic [7:0] b,
                                                   input logic [7:0] c);
        logic [23:0] key;
        logic [1:0]  ph;
        key = {to_upper(a), to_upper(b), to_upper(c)};
        ph  = PH_NONE;
        for (int k = 0; k < NAME_COUNT; k++) begin
            if (key == DEVICE_NAMES[k]) begin
                ph = NEEDS_DIGIT[k] ? PH_DIGIT : PH_NAMED;
            end
        end
        return ph;
    endfunction

endpackage

@@ rtl/wpnc_in_reg.sv @@
// ----------------------------------------------------------------------------
// wpnc_in_reg
// Input register that holds one item until the checker core takes it.
// ----------------------------------------------------------------------------
module wpnc_in_reg
    import wpnc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_operation,
    input  logic [7:0] i_path_byte,
    input  logic       i_take,
    output logic       o_stall,
    output logic       o_item_valid,
    output t_item      o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  accept;

    assign o_stall      = r_valid && !i_take;
    assign accept       = i_valid && !o_stall;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= '{op: i_operation, pbyte: i_path_byte};
        end
    end

endmodule

@@ rtl/wpnc_core.sv @@
// ----------------------------------------------------------------------------
// wpnc_core
// Per-byte path walk: prefix detection, element checks and the verdict.
// ----------------------------------------------------------------------------
module wpnc_core
    import wpnc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    input  t_item   i_item,
    input  logic    i_out_free,
    output logic    o_take,
    output t_result o_result
);

    t_walk      r_walk;
    t_walk      n_walk;
    logic [2:0] r_seen;
    logic [2:0] n_seen;
    logic [7:0] r_head [3];
    logic [7:0] n_head [3];
    logic [2:0] r_lead;
    logic [2:0] n_lead;

    always_comb begin
        logic [7:0] c;
        t_walk      fw;
        logic       special;
        logic       fin_bad;
        logic [2:0] new_len;
        logic [1:0] npos_inc;

        c  = i_item.pbyte;
        fw = r_walk;
        n_head = r_head;
        n_lead = r_lead;
        n_seen = r_seen;
        n_walk = r_walk;

        special = (r_walk.elen == 3'd0) ||
                  ((r_walk.elen == 3'd1) && (r_head[0] == CH_DOT)) ||
                  ((r_walk.elen == 3'd2) && (r_head[0] == CH_DOT) && (r_head[1] == CH_DOT));
        fin_bad = !special && ((r_walk.phase == PH_NAMED) ||
                               (r_walk.prev == CH_SPACE) || (r_walk.prev == CH_DOT));
        new_len  = (r_walk.elen < LEN_MAX) ? (r_walk.elen + 3'd1) : LEN_MAX;
        npos_inc = (r_walk.npos < NPOS_MAX) ? (r_walk.npos + 2'd1) : r_walk.npos;

        if (is_delim(c)) begin
            fw.illegal = r_walk.illegal | fin_bad;
            fw.elen    = 3'd0;
            fw.phase   = PH_NONE;
            fw.npos    = npos_inc;
        end else if ((r_walk.npos == 2'd1) && (r_walk.elen == 3'd1) && (c == CH_COLON) &&
                     is_alpha(r_head[0])) begin
            fw.elen  = 3'd0;
            fw.phase = PH_NONE;
            fw.npos  = NPOS_MAX;
        end else begin
            fw.npos = npos_inc;
            if (!byte_allowed(c)) begin
                fw.illegal = 1'b1;
            end
            if (r_walk.elen < HEAD_LEN) begin
                n_head[r_walk.elen[1:0]] = c;
            end
            fw.elen = new_len;
            if (new_len == 3'd3) begin
                fw.phase = device_phase_of(r_head[0], r_head[1], c);
            end else if ((new_len == 3'd4) && (r_walk.phase == PH_DIGIT)) begin
                fw.phase = is_digit19(c) ? PH_NAMED : PH_NONE;
            end else if ((new_len >= 3'd4) && (r_walk.phase == PH_NAMED)) begin
                if (c == CH_DOT) begin
                    fw.illegal = 1'b1;
                    fw.phase   = PH_NONE;
                end else if (c != CH_SPACE) begin
                    fw.phase = PH_NONE;
                end
            end
            fw.prev = c;
        end

        o_take   = i_item_valid && ((i_item.op == OP_BYTE) || i_out_free);
        o_result = '{load: 1'b0, illegal: r_walk.illegal | fin_bad};

        if (o_take) begin
            case (i_item.op)
                OP_BYTE: begin
                    n_walk = fw;
                    if (r_seen < LEAD_LEN) begin
                        n_seen = r_seen + 3'd1;
                        case (r_seen[1:0])
                            2'd0: n_lead[0] = is_delim(c);
                            2'd1: n_lead[1] = is_delim(c);
                            2'd2: n_lead[2] = (c == CH_QUEST);
                            default: begin
                                if (r_lead[0] && r_lead[1] && is_delim(c)) begin
                                    n_walk         = WALK_RESET;
                                    n_walk.illegal = !r_lead[2];
                                end
                            end
                        endcase
                    end
                end
                OP_END: begin
                    o_result.load = 1'b1;
                    n_walk        = WALK_RESET;
                    n_seen        = 3'd0;
                end
                default: begin
                    n_walk = r_walk;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk <= WALK_RESET;
            r_seen <= 3'd0;
        end else begin
            r_walk <= n_walk;
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_lead <= n_lead;
    end

endmodule

@@ rtl/wpnc_out_reg.sv @@
// ----------------------------------------------------------------------------
// wpnc_out_reg
// Result register that holds one verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module wpnc_out_reg
    import wpnc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_valid,
    output logic    o_path_illegal,
    output logic    o_free
);

    logic r_valid;
    logic n_valid;
    logic r_illegal;

    assign o_free         = !r_valid || !i_stall;
    assign o_valid        = r_valid;
    assign o_path_illegal = r_illegal;

    always_comb begin
        n_valid = r_valid;
        if (i_result.load) begin
            n_valid = 1'b1;
        end else if (o_free) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.load) begin
            r_illegal <= i_result.illegal;
        end
    end

endmodule

@@ rtl/windows_path_name_checker_unit.sv @@
// ----------------------------------------------------------------------------
// windows_path_name_checker_unit
// Streaming legality check of a path name, one byte per transfer.
// ----------------------------------------------------------------------------
// A path arrives as byte transfers followed by one end-of-path transfer, and
// the block accepts one transfer in every clock cycle while it is not stalled.
// Each transfer is held in the input register, and the per-byte walk state is
// updated from it when the core takes it. The verdict for a path is loaded into
// the result register when the core takes its end-of-path transfer from the
// input register, and it is offered from then on until the receiver takes it.
// The input side stalls only when an end-of-path transfer finds the result
// register full and stalled.
// After the verdict the block is ready for the next path with no gap.
module windows_path_name_checker_unit
    import wpnc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_operation,
    input  logic [7:0] i_path_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_path_illegal
);

    logic    item_valid;
    t_item   item;
    logic    take;
    logic    out_free;
    t_result result;

    wpnc_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_operation  (i_operation),
        .i_path_byte  (i_path_byte),
        .i_take       (take),
        .o_stall      (o_in_stall),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    wpnc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .i_out_free   (out_free),
        .o_take       (take),
        .o_result     (result)
    );

    wpnc_out_reg u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_result       (result),
        .i_stall        (i_out_stall),
        .o_valid        (o_out_valid),
        .o_path_illegal (o_path_illegal),
        .o_free         (out_free)
    );

endmodule

@@ rtl/wpnc_checker.sv @@
// ----------------------------------------------------------------------------
// wpnc_checker
// Port-level assertions for the path name checker, bound to the top level.
// ----------------------------------------------------------------------------
`include "windows_path_name_checker_unit_assert.svh"

module wpnc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_path_illegal
);

    `WPNC_ASSERT_AFTER_RESET(a_out_empty_after_reset, i_clk, i_rst_n,
        !o_out_valid, "Result offered right after reset.")
    `WPNC_ASSERT_AFTER_RESET(a_in_open_after_reset, i_clk, i_rst_n,
        !o_in_stall, "Input stalled right after reset.")
    `WPNC_ASSERT_NOW(a_stall_needs_full_out, i_clk, i_rst_n,
        o_in_stall, o_out_valid && i_out_stall, "Input stalled without a blocked result.")
    `WPNC_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n,
        o_out_valid && i_out_stall, o_out_valid && $stable(o_path_illegal),
        "Stalled result changed or dropped.")

endmodule

bind windows_path_name_checker_unit wpnc_checker u_checker (.*);
